@@ rtl/rtsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsd_pkg: shared types and constants
// Store size, result codes, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package rtsd_pkg;

    localparam int STORE_BYTES = 65536;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int LEN_W       = 17;

    localparam logic [LEN_W-1:0] STORE_LIMIT  = LEN_W'(STORE_BYTES);
    localparam logic [LEN_W-1:0] MIN_FILE_LEN = 17'h00311;
    localparam logic [LEN_W-1:0] DATA_START   = 17'h00310;
    localparam logic [LEN_W-1:0] PTR_TABLE    = 17'h00300;
    localparam logic [7:0]       TRK0_END     = 8'h40;

    // result status codes; decode phase shares codes 2..7
    typedef enum logic [2:0] {
        ST_FRAME      = 3'd0,
        ST_TRACK_DONE = 3'd1,
        ST_ALL_DONE   = 3'd2,
        ST_SHORT      = 3'd3,
        ST_BAD_PTR    = 3'd4,
        ST_DATA_END   = 3'd5,
        ST_BAD_ENV    = 3'd6,
        ST_OVERFLOW   = 3'd7
    } status_t;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_RUN   = 3'd1;
    localparam logic [2:0] PH_DONE  = 3'd2;

    typedef enum logic [2:0] {
        AS_PTR_LO  = 3'd0,
        AS_PTR_HI  = 3'd1,
        AS_RP      = 3'd2,
        AS_TAB_LO  = 3'd3,
        AS_TAB_HI  = 3'd4,
        AS_TAB_CNT = 3'd5,
        AS_OFFS    = 3'd6,
        AS_OFFS1   = 3'd7
    } addr_sel_t;

    typedef struct packed {
        logic      load;
        logic      ram_re;
        addr_sel_t addr_sel;
        logic      rp_inc;
        logic      ptr_load;
        logic      byte_latch;
        logic      code_latch;
        logic      offs_lo;
        logic      offs_hi;
        logic      code_tab;
        logic      exec_prep;
        logic      rem_dec;
        logic      fc_inc;
        logic      offs_add2;
        logic      push_frame;
        logic      push_env;
        logic      end_track;
        logic      fail;
        status_t   fail_code;
        logic      close;
    } rtsd_cmd_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       short_file;
        logic       bad_ptr;
        logic       fc_done;
        logic       rp_past;
        logic       code_table;
        logic       code_env;
        logic       trk0_end;
        logic       lit_one;
        logic       bad_env;
        logic       rem_zero;
        logic       fc_over;
        logic       env_past;
        logic       can_push;
        logic       hold_valid;
    } rtsd_stat_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] frame_index;
        logic [3:0]  reg_first;
        logic [3:0]  reg_second;
        logic [7:0]  value_first;
        logic [7:0]  value_second;
        logic        last;
    } rtsd_res_t;

endpackage

@@ rtl/rtsd_ram.sv @@
// ----------------------------------------------------------------------------
// rtsd_ram: generic memory
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module rtsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rtsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtsd_ctrl: decode sequencer
// Walks one code per decode request: pointer fetch, code and operand reads, frame loop.
// ----------------------------------------------------------------------------
module rtsd_ctrl
    import rtsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_func,
    output logic       s_ready,
    input  rtsd_stat_t st,
    output rtsd_cmd_t  cmd
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_START  = 19'h00002,
        S_PTR1   = 19'h00004,
        S_PTR2   = 19'h00008,
        S_CHKEND = 19'h00010,
        S_CODE   = 19'h00020,
        S_DISP   = 19'h00040,
        S_TAB1   = 19'h00080,
        S_TAB2   = 19'h00100,
        S_TAB3   = 19'h00200,
        S_LIT1   = 19'h00400,
        S_LIT2   = 19'h00800,
        S_EXEC   = 19'h01000,
        S_FRAME  = 19'h02000,
        S_ENV1   = 19'h04000,
        S_ENV2   = 19'h08000,
        S_ENDT   = 19'h10000,
        S_FAIL   = 19'h20000,
        S_CLOSE  = 19'h40000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_func) begin
                        state_next = S_START;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_START: begin
                if (st.phase >= PH_DONE) begin
                    code_next  = status_t'(st.phase);
                    state_next = S_FAIL;
                end else if (st.phase == PH_START) begin
                    if (st.short_file) begin
                        code_next  = ST_SHORT;
                        state_next = S_FAIL;
                    end else begin
                        cmd.ram_re   = 1'b1;
                        cmd.addr_sel = AS_PTR_LO;
                        state_next   = S_PTR1;
                    end
                end else begin
                    state_next = S_CHKEND;
                end
            end
            S_PTR1: begin
                cmd.byte_latch = 1'b1;
                cmd.ram_re     = 1'b1;
                cmd.addr_sel   = AS_PTR_HI;
                state_next     = S_PTR2;
            end
            S_PTR2: begin
                if (st.bad_ptr) begin
                    code_next  = ST_BAD_PTR;
                    state_next = S_FAIL;
                end else begin
                    cmd.ptr_load = 1'b1;
                    state_next   = S_CHKEND;
                end
            end
            S_CHKEND: begin
                if (st.fc_done) begin
                    state_next = S_ENDT;
                end else if (st.rp_past) begin
                    code_next  = ST_DATA_END;
                    state_next = S_FAIL;
                end else begin
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = AS_RP;
                    cmd.rp_inc   = 1'b1;
                    state_next   = S_CODE;
                end
            end
            S_CODE: begin
                cmd.code_latch = 1'b1;
                state_next     = S_DISP;
            end
            S_DISP: begin
                if (st.code_table) begin
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = AS_TAB_LO;
                    state_next   = S_TAB1;
                end else if (st.rp_past) begin
                    code_next  = ST_DATA_END;
                    state_next = S_FAIL;
                end else begin
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = AS_RP;
                    cmd.rp_inc   = 1'b1;
                    state_next   = S_LIT1;
                end
            end
            S_TAB1: begin
                cmd.offs_lo  = 1'b1;
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = AS_TAB_HI;
                state_next   = S_TAB2;
            end
            S_TAB2: begin
                cmd.offs_hi  = 1'b1;
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = AS_TAB_CNT;
                state_next   = S_TAB3;
            end
            S_TAB3: begin
                cmd.code_tab = 1'b1;
                state_next   = S_EXEC;
            end
            S_LIT1: begin
                cmd.offs_lo = 1'b1;
                if (st.lit_one) begin
                    state_next = S_EXEC;
                end else if (st.rp_past) begin
                    code_next  = ST_DATA_END;
                    state_next = S_FAIL;
                end else begin
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = AS_RP;
                    cmd.rp_inc   = 1'b1;
                    state_next   = S_LIT2;
                end
            end
            S_LIT2: begin
                cmd.offs_hi = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC: begin
                if (st.trk0_end) begin
                    state_next = S_ENDT;
                end else if (st.bad_env) begin
                    code_next  = ST_BAD_ENV;
                    state_next = S_FAIL;
                end else begin
                    cmd.exec_prep = 1'b1;
                    state_next    = S_FRAME;
                end
            end
            // one frame per pass; dropped frames only advance the frame and run counters
            S_FRAME: begin
                if (st.rem_zero) begin
                    state_next = S_CLOSE;
                end else if (st.fc_over) begin
                    code_next  = ST_OVERFLOW;
                    state_next = S_FAIL;
                end else if (st.fc_done) begin
                    cmd.fc_inc  = 1'b1;
                    cmd.rem_dec = 1'b1;
                end else if (st.code_env) begin
                    if (st.env_past) begin
                        code_next  = ST_DATA_END;
                        state_next = S_FAIL;
                    end else begin
                        cmd.ram_re   = 1'b1;
                        cmd.addr_sel = AS_OFFS;
                        state_next   = S_ENV1;
                    end
                end else if (st.can_push) begin
                    cmd.push_frame = 1'b1;
                    cmd.fc_inc     = 1'b1;
                    cmd.rem_dec    = 1'b1;
                end
            end
            S_ENV1: begin
                cmd.byte_latch = 1'b1;
                cmd.ram_re     = 1'b1;
                cmd.addr_sel   = AS_OFFS1;
                state_next     = S_ENV2;
            end
            S_ENV2: begin
                if (st.can_push) begin
                    cmd.push_frame = 1'b1;
                    cmd.push_env   = 1'b1;
                    cmd.offs_add2  = 1'b1;
                    cmd.fc_inc     = 1'b1;
                    cmd.rem_dec    = 1'b1;
                    state_next     = S_FRAME;
                end
            end
            S_ENDT: begin
                if (st.can_push) begin
                    cmd.end_track = 1'b1;
                    state_next    = S_CLOSE;
                end
            end
            S_FAIL: begin
                if (st.can_push) begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = code_reg;
                    state_next    = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (!st.hold_valid) begin
                    state_next = S_IDLE;
                end else if (st.can_push) begin
                    cmd.close  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_FRAME;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

@@ rtl/rtsd_dp.sv @@
// ----------------------------------------------------------------------------
// rtsd_dp: decoder datapath
// File store, track state, operand registers, hold stage and output register.
// ----------------------------------------------------------------------------
module rtsd_dp
    import rtsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_byte_index,
    input  logic [7:0]  s_byte_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_load_page,
    input  rtsd_cmd_t   cmd,
    output rtsd_stat_t  st,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_frame_index,
    output logic [3:0]  m_reg_first,
    output logic [3:0]  m_reg_second,
    output logic [7:0]  m_value_first,
    output logic [7:0]  m_value_second,
    output logic        m_last
);

    logic [7:0]       page_reg, page_next;
    logic [LEN_W-1:0] flen_reg, flen_next;
    logic [2:0]       trk_reg, trk_next;
    logic [LEN_W-1:0] rp_reg, rp_next;
    logic [LEN_W-1:0] fc_reg, fc_next;
    logic [LEN_W-1:0] ftot_reg, ftot_next;
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       code_reg, code_next;
    logic [LEN_W-1:0] offs_reg, offs_next;
    logic [7:0]       byte_reg, byte_next;
    logic [6:0]       rem_reg, rem_next;
    rtsd_res_t        hold_reg, hold_next;
    logic             hold_valid_reg, hold_valid_next;
    rtsd_res_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]       rdata;
    logic [LEN_W-1:0] raddr;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] idx_ext;
    logic [LEN_W-1:0] idx_len;
    logic             idx_ok;
    logic [LEN_W-1:0] ptr_val;
    logic [7:0]       tab_e;
    logic             trk_lo;
    logic [3:0]       reg_a;
    logic [3:0]       reg_b;
    logic             out_free;
    logic             push;
    rtsd_res_t        item;

    assign base    = {1'b0, page_reg, 8'h00};
    assign limit   = base + DATA_START;
    assign idx_ext = {1'b0, s_byte_index};
    assign idx_len = idx_ext + 17'd1;
    assign idx_ok  = idx_ext < STORE_LIMIT;
    assign ptr_val = {1'b0, rdata, byte_reg};
    assign tab_e   = {code_reg[6:0], 1'b0};
    assign trk_lo  = !trk_reg[2];
    assign reg_a   = trk_lo ? {1'b0, trk_reg[1:0], 1'b0} : ({1'b0, trk_reg} + 4'd4);
    assign reg_b   = trk_lo ? (reg_a + 4'd1) : (reg_a + 4'd4);

    // read address select
    always_comb begin
        case (cmd.addr_sel)
            AS_PTR_LO:  raddr = PTR_TABLE + {13'd0, trk_reg, 1'b0};
            AS_PTR_HI:  raddr = PTR_TABLE + {13'd0, trk_reg, 1'b1};
            AS_RP:      raddr = rp_reg;
            AS_TAB_LO:  raddr = trk_lo ? {9'd0, tab_e} : ({9'd0, tab_e} | 17'h00200);
            AS_TAB_HI:  raddr = trk_lo ? ({9'd0, tab_e} | 17'h00001)
                                       : ({9'd0, tab_e} | 17'h00201);
            AS_TAB_CNT: raddr = trk_lo ? ({9'd0, tab_e} | 17'h00100)
                                       : ({9'd0, tab_e} | 17'h00101);
            AS_OFFS:    raddr = offs_reg;
            AS_OFFS1:   raddr = offs_reg + 17'd1;
            default:    raddr = rp_reg;
        endcase
    end

    rtsd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.load && idx_ok),
        .waddr (s_byte_index[ADDR_W-1:0]),
        .wdata (s_byte_value),
        .re    (cmd.ram_re),
        .raddr (raddr[ADDR_W-1:0]),
        .rdata (rdata)
    );

    // status toward the sequencer
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        st.phase      = phase_reg;
        st.short_file = (trk_reg == 3'd0) && (flen_reg < MIN_FILE_LEN);
        st.bad_ptr    = ptr_val < limit;
        st.fc_done    = (trk_reg != 3'd0) && (fc_reg >= ftot_reg);
        st.rp_past    = rp_reg >= flen_reg;
        st.code_table = code_reg[7];
        st.code_env   = code_reg[6];
        st.trk0_end   = (code_reg == TRK0_END) && (trk_reg == 3'd0);
        st.lit_one    = !code_reg[6] && (trk_reg == 3'd3);
        st.bad_env    = code_reg[6] && (offs_reg < limit);
        st.rem_zero   = rem_reg == 7'd0;
        st.fc_over    = (trk_reg == 3'd0) && fc_reg[16];
        st.env_past   = (offs_reg + 17'd1) >= flen_reg;
        st.can_push   = !hold_valid_reg || out_free;
        st.hold_valid = hold_valid_reg;
    end

    // result item to push into the hold stage
    always_comb begin
        item = '0;
        push = cmd.push_frame || cmd.end_track || cmd.fail;
        if (cmd.push_frame) begin
            item.status       = ST_FRAME;
            item.frame_index  = fc_reg[15:0];
            item.reg_first    = reg_a;
            item.reg_second   = reg_b;
            item.value_first  = cmd.push_env ? byte_reg : offs_reg[7:0];
            item.value_second = cmd.push_env ? rdata : offs_reg[15:8];
            if (trk_reg == 3'd3) begin
                item.value_second = 8'h00;
            end
        end else if (cmd.end_track) begin
            item.status = (trk_reg == 3'd7) ? ST_ALL_DONE : ST_TRACK_DONE;
        end else begin
            item.status = cmd.fail_code;
        end
    end

    // state updates
    always_comb begin
        page_next       = page_reg;
        flen_next       = flen_reg;
        trk_next        = trk_reg;
        rp_next         = rp_reg;
        fc_next         = fc_reg;
        ftot_next       = ftot_reg;
        phase_next      = phase_reg;
        code_next       = code_reg;
        offs_next       = offs_reg;
        byte_next       = byte_reg;
        rem_next        = rem_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_valid) begin
            page_next = cfg_load_page;
        end
        if (cmd.load) begin
            if (idx_ok && (idx_len > flen_reg)) begin
                flen_next = idx_len;
            end
            trk_next   = 3'd0;
            rp_next    = '0;
            fc_next    = '0;
            ftot_next  = '0;
            phase_next = PH_START;
        end
        if (cmd.ptr_load) begin
            rp_next    = ptr_val - base;
            phase_next = PH_RUN;
        end
        if (cmd.rp_inc) begin
            rp_next = rp_reg + 17'd1;
        end
        if (cmd.byte_latch) begin
            byte_next = rdata;
        end
        if (cmd.code_latch) begin
            code_next = rdata;
        end
        if (cmd.code_tab) begin
            code_next = {1'b0, rdata[7:1]};
        end
        if (cmd.offs_lo) begin
            offs_next = {9'd0, rdata};
        end
        if (cmd.offs_hi) begin
            offs_next = {1'b0, rdata, offs_reg[7:0]};
        end
        if (cmd.exec_prep) begin
            if (code_reg[6]) begin
                offs_next = offs_reg - base;
            end
            rem_next = {1'b0, code_reg[5:0]} + 7'd1;
        end
        if (cmd.rem_dec) begin
            rem_next = rem_reg - 7'd1;
        end
        if (cmd.fc_inc) begin
            fc_next = fc_reg + 17'd1;
        end
        if (cmd.offs_add2) begin
            offs_next = offs_reg + 17'd2;
        end
        if (cmd.end_track) begin
            if (trk_reg == 3'd0) begin
                ftot_next = fc_reg;
            end
            fc_next = '0;
            if (trk_reg == 3'd7) begin
                phase_next = PH_DONE;
            end else begin
                trk_next   = trk_reg + 3'd1;
                phase_next = PH_START;
            end
        end
        if (cmd.fail) begin
            phase_next = cmd.fail_code;
        end

        // output register drains on transfer
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        // hold stage delays each item until its last flag is known
        if (push) begin
            if (hold_valid_reg) begin
                out_next       = hold_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
            hold_next       = item;
            hold_valid_next = 1'b1;
        end
        if (cmd.close && hold_valid_reg) begin
            out_next        = hold_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg       <= 8'd16;
            flen_reg       <= '0;
            trk_reg        <= '0;
            rp_reg         <= '0;
            fc_reg         <= '0;
            ftot_reg       <= '0;
            phase_reg      <= PH_START;
            rem_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            page_reg       <= page_next;
            flen_reg       <= flen_next;
            trk_reg        <= trk_next;
            rp_reg         <= rp_next;
            fc_reg         <= fc_next;
            ftot_reg       <= ftot_next;
            phase_reg      <= phase_next;
            rem_reg        <= rem_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        offs_reg <= offs_next;
        byte_reg <= byte_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign cfg_ready      = 1'b1;
    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_frame_index  = out_reg.frame_index;
    assign m_reg_first    = out_reg.reg_first;
    assign m_reg_second   = out_reg.reg_second;
    assign m_value_first  = out_reg.value_first;
    assign m_value_second = out_reg.value_second;
    assign m_last         = out_reg.last;

    // a push over a full hold stage needs room downstream
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && hold_valid_reg) |-> out_free)
        else $error("hold stage overwritten while output stalled");

    // non-frame results always end a request
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.status != ST_FRAME)) |-> out_reg.last)
        else $error("status result without last");

    // non-frame results carry zero payload
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.status != ST_FRAME)) |->
        (out_reg.frame_index == 16'd0 && out_reg.value_first == 8'd0 &&
         out_reg.value_second == 8'd0 && out_reg.reg_first == 4'd0))
        else $error("status result with payload");

    // run counter never wraps
    a_rem_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem_dec |-> (rem_reg != 7'd0))
        else $error("frame run counter underflow");

endmodule

@@ rtl/register_track_stream_decompressor.sv @@
// ----------------------------------------------------------------------------
// register_track_stream_decompressor: top level
// Loads a compressed register-track file and decodes it one code per request.
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | func, byte_index, byte_value
//   m_      | out       | m_valid / m_ready   | status, frame_index, regs, values, last
//   cfg_    | in        | cfg_valid/cfg_ready | load_page
//
// A load writes one byte into the store. A decode request performs pointer,
// code and operand reads on the single store read port, then emits constant
// frames or envelope frames, which take two more store reads each, up to 64
// frames, and then closes. Error and track-end answers add a result and a close.
// Reset is synchronous; the file store is not cleared and holds garbage until
// loaded. A stalled m_ channel holds the sequencer once the output register
// and the hold stage are both full.
// ----------------------------------------------------------------------------
module register_track_stream_decompressor
    import rtsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_byte_index,
    input  logic [7:0]  s_byte_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_load_page,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_frame_index,
    output logic [3:0]  m_reg_first,
    output logic [3:0]  m_reg_second,
    output logic [7:0]  m_value_first,
    output logic [7:0]  m_value_second,
    output logic        m_last
);

    rtsd_cmd_t  cmd;
    rtsd_stat_t st;

    rtsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rtsd_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_byte_index   (s_byte_index),
        .s_byte_value   (s_byte_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_load_page  (cfg_load_page),
        .cmd            (cmd),
        .st             (st),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_frame_index  (m_frame_index),
        .m_reg_first    (m_reg_first),
        .m_reg_second   (m_reg_second),
        .m_value_first  (m_value_first),
        .m_value_second (m_value_second),
        .m_last         (m_last)
    );

endmodule
